>>> sv/epd_pkg.sv
// Shared types and constants for the encoder PD motor drive.
// Used by the controller, the datapath and the top level; depends on nothing.
package epd_pkg;

    // Default depth of the window of recent encoder counts.
    localparam int WINDOW_DEPTH_DEF = 8;

    // Two pi in Q15.16, rounded, and the reduction constants built from it.
    localparam int          TWO_PI_Q16 = 411775;
    localparam logic [19:0] TWO_PI_20  = 20'(TWO_PI_Q16);
    // 2^47 modulo two pi; the weight of the sign bit of the floored angle product.
    localparam longint      SIGN_MOD   = (64'sd1 <<< 47) % 64'(TWO_PI_Q16);
    localparam logic [20:0] SIGN_MOD_21 = 21'(SIGN_MOD);

    // The reduction walks 48 bits, two bits per cycle.
    localparam int          MOD_STEPS = 24;
    localparam logic [4:0]  MOD_LAST  = 5'(MOD_STEPS - 1);

    // Configuration register indexes.
    localparam logic [2:0] REG_CONTROL_MODE   = 3'd0;
    localparam logic [2:0] REG_OUTPUT_MAX     = 3'd1;
    localparam logic [2:0] REG_COUNT_TO_ANGLE = 3'd2;
    localparam logic [2:0] REG_COUNT_TO_SPEED = 3'd3;
    localparam logic [2:0] REG_POS_GAIN_P     = 3'd4;
    localparam logic [2:0] REG_POS_GAIN_D     = 3'd5;
    localparam logic [2:0] REG_VEL_GAIN_P     = 3'd6;
    localparam logic [2:0] REG_VEL_GAIN_D     = 3'd7;

    // Control modes.
    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        OP_SPEED = 2'd0,
        OP_ANGLE = 2'd1,
        OP_GAIN_P = 2'd2,
        OP_GAIN_D = 2'd3
    } op_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    win_update;
        op_sel_t op_sel;
        logic    mod_load;
        logic    mod_step;
        logic    fix;
        logic    err;
        logic    pprod_load;
        logic    acc_load;
        logic    trunc;
        logic    drv_load;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_done;
        logic mode_active;
        logic out_free;
    } status_t;

endpackage

>>> sv/encoder_pd_motor_drive.sv
// Encoder-fed PD motor drive, velocity form. Each request carries one sample
// period: a signed encoder count delta and a target, and gives one result with
// the clamped drive, the measured angle in [0, 2pi) and the measured speed.
// The block works on one request at a time; each request runs through the
// angle reduction (two bits per cycle) and up to four passes through the single
// shared 34 by 34 multiplier. A finished result waits in an output register, so
// the next request is taken while it is still pending. Configuration writes are
// always accepted.
module encoder_pd_motor_drive #(
    parameter int WINDOW_DEPTH = epd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // count_delta[15:0], target[47:16]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // drive[15:0], angle[34:16], speed[66:35], zero
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    logic [1:0]  control_mode_reg;
    logic [14:0] output_max_reg;
    logic [31:0] count_to_angle_reg;
    logic [31:0] count_to_speed_reg;
    logic [23:0] pos_gain_p_reg;
    logic [23:0] pos_gain_d_reg;
    logic [23:0] vel_gain_p_reg;
    logic [23:0] vel_gain_d_reg;

    epd_pkg::cmd_t    cmd;
    epd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg   <= 2'd0;
            output_max_reg     <= 15'h7FFF;
            count_to_angle_reg <= 32'd0;
            count_to_speed_reg <= 32'd0;
            pos_gain_p_reg     <= 24'd0;
            pos_gain_d_reg     <= 24'd0;
            vel_gain_p_reg     <= 24'd0;
            vel_gain_d_reg     <= 24'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                epd_pkg::REG_CONTROL_MODE:   control_mode_reg   <= cfg_data[1:0];
                epd_pkg::REG_OUTPUT_MAX:     output_max_reg     <= cfg_data[14:0];
                epd_pkg::REG_COUNT_TO_ANGLE: count_to_angle_reg <= cfg_data;
                epd_pkg::REG_COUNT_TO_SPEED: count_to_speed_reg <= cfg_data;
                epd_pkg::REG_POS_GAIN_P:     pos_gain_p_reg     <= cfg_data[23:0];
                epd_pkg::REG_POS_GAIN_D:     pos_gain_d_reg     <= cfg_data[23:0];
                epd_pkg::REG_VEL_GAIN_P:     vel_gain_p_reg     <= cfg_data[23:0];
                epd_pkg::REG_VEL_GAIN_D:     vel_gain_d_reg     <= cfg_data[23:0];
                default:                     control_mode_reg   <= control_mode_reg;
            endcase
        end
    end

    epd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .AW           (AW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .count_delta    (s_tdata[15:0]),
        .target         (s_tdata[47:16]),
        .control_mode   (control_mode_reg),
        .output_max     (output_max_reg),
        .count_to_angle (count_to_angle_reg),
        .count_to_speed (count_to_speed_reg),
        .pos_gain_p     (pos_gain_p_reg),
        .pos_gain_d     (pos_gain_d_reg),
        .vel_gain_p     (vel_gain_p_reg),
        .vel_gain_d     (vel_gain_d_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata)
    );

endmodule

>>> sv/epd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the datapath for the count window.
module epd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/epd_datapath.sv
// Datapath of the encoder PD motor drive: count window, shared multiplier,
// angle reduction, PD term and output register. Depends on epd_pkg and epd_ram.
module epd_datapath #(
    parameter int WINDOW_DEPTH = epd_pkg::WINDOW_DEPTH_DEF,
    parameter int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  epd_pkg::cmd_t       cmd,
    output epd_pkg::status_t    status,
    input  logic [15:0]         count_delta,
    input  logic [31:0]         target,
    input  logic [1:0]          control_mode,
    input  logic [14:0]         output_max,
    input  logic [31:0]         count_to_angle,
    input  logic [31:0]         count_to_speed,
    input  logic [23:0]         pos_gain_p,
    input  logic [23:0]         pos_gain_d,
    input  logic [23:0]         vel_gain_p,
    input  logic [23:0]         vel_gain_d,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [71:0]         m_tdata
);

    // Captured request.
    logic [15:0] cd_reg;
    logic [31:0] target_reg;

    // Window state.
    logic [AW-1:0]           head_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [15:0]             ws_reg;
    logic [31:0]             total_reg;
    logic [15:0]             ram_rdata;
    logic [15:0]             old_count;

    // Multiplier.
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p_reg;

    // Angle reduction.
    logic [47:0] mod_sh_reg;
    logic        mod_sign_reg;
    logic [18:0] mod_r_reg;
    logic [4:0]  mod_cnt_reg;
    logic [19:0] mod_r1;
    logic [19:0] mod_r2;
    logic signed [20:0] fix_t;
    logic signed [20:0] fix_v;

    // Results and PD state.
    logic [18:0]        ang_reg;
    logic [31:0]        spd_reg;
    logic signed [32:0] e_reg;
    logic signed [33:0] diff_reg;
    logic signed [32:0] last_error_reg;
    logic signed [15:0] last_drive_reg;
    logic signed [59:0] pprod_reg;
    logic signed [59:0] acc_reg;
    logic signed [15:0] term_reg;
    logic signed [15:0] drive_reg;
    logic signed [32:0] e_next;
    logic signed [32:0] meas;
    logic signed [59:0] acc_adj;
    logic signed [31:0] term_wide;
    logic signed [15:0] term_sat;
    logic signed [16:0] drv_sum;
    logic signed [16:0] lim;
    logic signed [15:0] drv_clamp;
    logic [23:0]        gain_p;
    logic [23:0]        gain_d;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_drive_reg;
    logic [18:0] out_angle_reg;
    logic [31:0] out_speed_reg;

    // Window memory, read at the head when a request is accepted.
    epd_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_window (
        .clk   (clk),
        .we    (cmd.win_update),
        .waddr (head_reg),
        .wdata (cd_reg),
        .re    (cmd.accept),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign old_count = valid_reg[head_reg] ? ram_rdata : 16'd0;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cd_reg     <= count_delta;
            target_reg <= target;
        end
    end

    // Window sum, running total and head pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            valid_reg <= '0;
            ws_reg    <= 16'd0;
            total_reg <= 32'd0;
        end
        else if (cmd.win_update)
        begin
            ws_reg              <= ws_reg - old_count + cd_reg;
            total_reg           <= total_reg + {{16{cd_reg[15]}}, cd_reg};
            valid_reg[head_reg] <= 1'b1;
            if (head_reg == AW'(WINDOW_DEPTH - 1))
            begin
                head_reg <= '0;
            end
            else
            begin
                head_reg <= head_reg + 1'b1;
            end
        end
    end

    // Gain selection by mode.
    assign gain_p = control_mode[0] ? vel_gain_p : pos_gain_p;
    assign gain_d = control_mode[0] ? vel_gain_d : pos_gain_d;

    // Operand selection of the shared multiplier.
    always_comb
    begin
        case (cmd.op_sel)
            epd_pkg::OP_ANGLE:
            begin
                mul_a = -$signed({{2{total_reg[31]}}, total_reg});
                mul_b = $signed({2'b00, count_to_angle});
            end
            epd_pkg::OP_GAIN_P:
            begin
                mul_a = $signed({{10{gain_p[23]}}, gain_p});
                mul_b = $signed({e_reg[32], e_reg});
            end
            epd_pkg::OP_GAIN_D:
            begin
                mul_a = $signed({{10{gain_d[23]}}, gain_d});
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = -$signed({{18{ws_reg[15]}}, ws_reg});
                mul_b = $signed({2'b00, count_to_speed});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // Two restoring steps of the modulo reduction per cycle.
    always_comb
    begin
        mod_r1 = {mod_r_reg, mod_sh_reg[47]};
        if (mod_r1 >= epd_pkg::TWO_PI_20)
        begin
            mod_r1 = mod_r1 - epd_pkg::TWO_PI_20;
        end
        mod_r2 = {mod_r1[18:0], mod_sh_reg[46]};
        if (mod_r2 >= epd_pkg::TWO_PI_20)
        begin
            mod_r2 = mod_r2 - epd_pkg::TWO_PI_20;
        end
    end

    // The sign bit weighs -2^47, folded in once the low bits are reduced.
    always_comb
    begin
        fix_t = $signed({2'b00, mod_r_reg}) - $signed(epd_pkg::SIGN_MOD_21);
        if (!mod_sign_reg)
        begin
            fix_v = $signed({2'b00, mod_r_reg});
        end
        else if (fix_t < 0)
        begin
            fix_v = fix_t + $signed({1'b0, epd_pkg::TWO_PI_20});
        end
        else
        begin
            fix_v = fix_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_cnt_reg <= 5'd0;
        end
        else if (cmd.mod_load)
        begin
            mod_cnt_reg <= 5'd0;
        end
        else if (cmd.mod_step)
        begin
            mod_cnt_reg <= mod_cnt_reg + 5'd1;
        end
    end

    // Floored angle product is a 48-bit signed value in mul_p_reg[63:16].
    always_ff @(posedge clk)
    begin
        if (cmd.mod_load)
        begin
            mod_sh_reg   <= {1'b0, mul_p_reg[62:16]};
            mod_sign_reg <= mul_p_reg[63];
            mod_r_reg    <= 19'd0;
        end
        else if (cmd.mod_step)
        begin
            mod_sh_reg <= {mod_sh_reg[45:0], 2'b00};
            mod_r_reg  <= mod_r2[18:0];
        end
        if (cmd.fix)
        begin
            ang_reg   <= fix_v[18:0];
            spd_reg   <= mul_p_reg[47:16];
            drive_reg <= 16'sd0;
        end
        if (cmd.err)
        begin
            e_reg    <= e_next;
            diff_reg <= $signed({e_next[32], e_next}) -
                        $signed({last_error_reg[32], last_error_reg});
        end
        if (cmd.pprod_load)
        begin
            pprod_reg <= mul_p_reg[59:0];
        end
        if (cmd.acc_load)
        begin
            acc_reg <= pprod_reg + mul_p_reg[59:0];
        end
        if (cmd.trunc)
        begin
            term_reg <= term_sat;
        end
        if (cmd.drv_load)
        begin
            drive_reg <= drv_clamp;
        end
    end

    // Error against the measured angle or speed.
    assign meas   = control_mode[0] ? $signed({spd_reg[31], spd_reg})
                                    : $signed({14'd0, ang_reg});
    assign e_next = $signed({target_reg[31], target_reg}) - meas;

    // Truncate toward zero to an integer and saturate to 16 bits.
    assign acc_adj   = acc_reg + (acc_reg[59] ? 60'sd268435455 : 60'sd0);
    assign term_wide = 32'(acc_adj >>> 28);
    always_comb
    begin
        if (term_wide > 32'sd32767)
        begin
            term_sat = 16'sd32767;
        end
        else if (term_wide < -32'sd32768)
        begin
            term_sat = -16'sd32768;
        end
        else
        begin
            term_sat = term_wide[15:0];
        end
    end

    // New drive, clamped to the symmetric limit.
    assign drv_sum = $signed({last_drive_reg[15], last_drive_reg}) +
                     $signed({term_reg[15], term_reg});
    assign lim     = $signed({2'b00, output_max});
    always_comb
    begin
        if (drv_sum > lim)
        begin
            drv_clamp = lim[15:0];
        end
        else if (drv_sum < -lim)
        begin
            drv_clamp = 16'(-lim);
        end
        else
        begin
            drv_clamp = drv_sum[15:0];
        end
    end

    // Loop state kept across samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= 33'sd0;
            last_drive_reg <= 16'sd0;
        end
        else
        begin
            if (cmd.trunc)
            begin
                last_error_reg <= e_reg;
            end
            if (cmd.drv_load)
            begin
                last_drive_reg <= drv_clamp;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_drive_reg <= drive_reg;
            out_angle_reg <= ang_reg;
            out_speed_reg <= spd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_speed_reg, out_angle_reg, out_drive_reg};

    assign status.mod_done    = (mod_cnt_reg == epd_pkg::MOD_LAST);
    assign status.mode_active = (control_mode == epd_pkg::MODE_POSITION) ||
                                (control_mode == epd_pkg::MODE_VELOCITY);
    assign status.out_free    = !out_valid_reg || m_tready;

    // The reduction remainder never reaches two pi.
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_step |=> mod_r_reg < epd_pkg::TWO_PI_20[18:0])
        else $error("angle remainder out of range");

    // A delivered angle is always inside [0, 2pi).
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_angle_reg < epd_pkg::TWO_PI_20[18:0])
        else $error("angle output out of range");

    // The clamp never lets the most negative code through.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drv_load |=> drive_reg != -16'sd32768)
        else $error("drive outside clamp");

endmodule

>>> sv/epd_ctrl.sv
// Controller state machine of the encoder PD motor drive: sequences the
// window update, multiplier passes and output. Depends on epd_pkg.
module epd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  epd_pkg::status_t status,
    output epd_pkg::cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_UPDATE  = 13'b0000000000010,
        S_MUL_ANG = 13'b0000000000100,
        S_MUL_SPD = 13'b0000000001000,
        S_MOD     = 13'b0000000010000,
        S_FIX     = 13'b0000000100000,
        S_ERR     = 13'b0000001000000,
        S_MUL_P   = 13'b0000010000000,
        S_MUL_D   = 13'b0000100000000,
        S_ACC     = 13'b0001000000000,
        S_TRUNC   = 13'b0010000000000,
        S_DRV     = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op_sel = epd_pkg::OP_SPEED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.win_update = 1'b1;
                state_next     = S_MUL_ANG;
            end
            S_MUL_ANG:
            begin
                cmd.op_sel = epd_pkg::OP_ANGLE;
                state_next = S_MUL_SPD;
            end
            S_MUL_SPD:
            begin
                cmd.mod_load = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = status.mode_active ? S_ERR : S_OUT;
            end
            S_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                cmd.op_sel = epd_pkg::OP_GAIN_P;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.op_sel     = epd_pkg::OP_GAIN_D;
                cmd.pprod_load = 1'b1;
                state_next     = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_load = 1'b1;
                state_next   = S_TRUNC;
            end
            S_TRUNC:
            begin
                cmd.trunc  = 1'b1;
                state_next = S_DRV;
            end
            S_DRV:
            begin
                cmd.drv_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // The reduction leaves for the fixup exactly when its count is done.
    a_mod_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && status.mod_done) |=> state_reg == S_FIX)
        else $error("reduction did not finish");

    // A request is only taken after the previous result was loaded into the output register.
    a_accept_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> $past(state_reg) == S_OUT || $past(state_reg) == S_IDLE)
        else $error("request accepted mid item");

    // An unused mode skips the PD passes.
    a_mode_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX && !status.mode_active) |=> state_reg == S_OUT)
        else $error("unused mode ran the PD term");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for encoder_pd_motor_drive: directed and random sample
// periods are checked against an in-bench model of the PD loop.
// Depends on epd_pkg and the encoder_pd_motor_drive top level.
`timescale 1ns / 100ps

module testbench;
    import epd_pkg::*;

    // Modes with no control action.
    localparam logic [1:0] MODE_OFF_A = 2'd2;
    localparam logic [1:0] MODE_OFF_B = 2'd3;
    localparam int         WIN_DEPTH  = 8;
    localparam int         IDLE_LIMIT = 5000;

    typedef struct packed {
        logic signed [15:0] drive;
        logic [18:0]        angle;
        logic signed [31:0] speed;
    } motor_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // count_delta[15:0], target[47:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // drive[15:0], angle[34:16], speed[66:35], zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Model copy of the configuration.
    logic [1:0]         mdl_mode;
    logic [14:0]        mdl_out_max;
    logic [31:0]        mdl_count_to_angle;
    logic [31:0]        mdl_count_to_speed;
    logic signed [23:0] mdl_pos_p;
    logic signed [23:0] mdl_pos_d;
    logic signed [23:0] mdl_vel_p;
    logic signed [23:0] mdl_vel_d;

    // Model copy of the loop state.
    logic [15:0]        mdl_window [WIN_DEPTH];
    int                 mdl_head;
    logic [15:0]        mdl_window_sum;
    logic [31:0]        mdl_count_total;
    longint             mdl_last_error;
    longint             mdl_last_drive;

    motor_result_t pending_results[$];
    int            error_count;
    int            result_count;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_off_cycles;
    int            quiet_cycles;

    encoder_pd_motor_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Compute the drive, angle and speed for one sample period and advance the state.
    function automatic motor_result_t next_sample(logic [15:0] delta, logic [31:0] target);
        motor_result_t res;
        longint        total;
        longint        ang;
        longint        spd;
        longint        err;
        longint        gp;
        longint        gd;
        longint        term;
        longint        drv;
        longint        lim;
        mdl_window_sum = mdl_window_sum - mdl_window[mdl_head] + delta;
        mdl_window[mdl_head] = delta;
        mdl_head = (mdl_head + 1) % WIN_DEPTH;
        mdl_count_total = mdl_count_total + {{16{delta[15]}}, delta};

        total = longint'(signed'(mdl_count_total));
        ang = ((-total * longint'(mdl_count_to_angle)) >>> 16) % longint'(TWO_PI_Q16);
        if (ang < 0)
        begin
            ang += longint'(TWO_PI_Q16);
        end
        spd = (-longint'(signed'(mdl_window_sum)) * longint'(mdl_count_to_speed)) >>> 16;

        drv = 0;
        if (mdl_mode == MODE_POSITION || mdl_mode == MODE_VELOCITY)
        begin
            if (mdl_mode == MODE_POSITION)
            begin
                err = longint'(signed'(target)) - ang;
                gp = longint'(mdl_pos_p);
                gd = longint'(mdl_pos_d);
            end
            else
            begin
                err = longint'(signed'(target)) - spd;
                gp = longint'(mdl_vel_p);
                gd = longint'(mdl_vel_d);
            end
            // Integer division truncates toward zero.
            term = (gp * err + gd * (err - mdl_last_error)) / 268435456;
            if (term > 32767) term = 32767;
            if (term < -32768) term = -32768;
            mdl_last_error = err;
            drv = mdl_last_drive + term;
            lim = longint'(mdl_out_max);
            if (drv > lim) drv = lim;
            if (drv < -lim) drv = -lim;
            mdl_last_drive = drv;
        end
        res.drive = drv[15:0];
        res.angle = ang[18:0];
        res.speed = spd[31:0];
        return res;
    endfunction

    // Send one sample request; valid stays high for a back-to-back follower.
    task automatic send_sample(logic [15:0] delta, logic [31:0] target);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {target, delta};
        pending_results.push_back(next_sample(delta, target));
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every result is back, plus the block's latency.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register and mirror it in the model (values masked to width).
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CONTROL_MODE:   mdl_mode = value[1:0];
            REG_OUTPUT_MAX:     mdl_out_max = value[14:0];
            REG_COUNT_TO_ANGLE: mdl_count_to_angle = value;
            REG_COUNT_TO_SPEED: mdl_count_to_speed = value;
            REG_POS_GAIN_P:     mdl_pos_p = value[23:0];
            REG_POS_GAIN_D:     mdl_pos_d = value[23:0];
            REG_VEL_GAIN_P:     mdl_vel_p = value[23:0];
            default:            mdl_vel_d = value[23:0];
        endcase
    endtask

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(3) == 0)
        begin
            return $urandom();
        end
        // Smallish gains with random junk above bit 23 to exercise the mask.
        return {$urandom_range(255), 24'(32'($urandom_range(8192)) - 32'd4096)};
    endfunction

    task automatic random_config;
        write_reg(REG_CONTROL_MODE, {$urandom_range(1), 1'b0} == 2 ? 32'(MODE_OFF_A)
                                    : 32'($urandom_range(1)));
        write_reg(REG_OUTPUT_MAX, $urandom());
        write_reg(REG_COUNT_TO_ANGLE, $urandom());
        write_reg(REG_COUNT_TO_SPEED, $urandom_range(3) == 0 ? $urandom() : $urandom_range(1 << 22));
        write_reg(REG_POS_GAIN_P, rand_gain());
        write_reg(REG_POS_GAIN_D, rand_gain());
        write_reg(REG_VEL_GAIN_P, rand_gain());
        write_reg(REG_VEL_GAIN_D, rand_gain());
    endtask

    task automatic send_random(int count);
        logic [15:0] delta;
        logic [31:0] target;
        for (int i = 0; i < count; i++)
        begin
            delta = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(400) - 200);
            target = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1 << 20) - (1 << 19));
            send_sample(delta, target);
        end
    endtask

    // Field extremes, every mode, clamp limits and a mode switch.
    task automatic test_directed;
        write_reg(REG_COUNT_TO_ANGLE, 32'hFFFF_FFFF);
        write_reg(REG_COUNT_TO_SPEED, 32'h0001_0000);
        write_reg(REG_POS_GAIN_P, 32'h0000_1000);
        write_reg(REG_POS_GAIN_D, 32'hFF80_0000);
        write_reg(REG_VEL_GAIN_P, 32'h007F_FFFF);
        write_reg(REG_VEL_GAIN_D, 32'h0000_0800);
        send_sample(16'h7FFF, 32'h7FFF_FFFF);
        send_sample(16'h8000, 32'h8000_0000);
        send_sample(16'h0000, 32'h0000_0000);
        send_sample(16'hFFFF, 32'h0001_0000);
        drain();
        write_reg(REG_CONTROL_MODE, 32'(MODE_VELOCITY));
        send_sample(16'h8000, 32'h7FFF_FFFF);
        send_sample(16'h7FFF, 32'h8000_0000);
        send_sample(16'h0001, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_OUTPUT_MAX, 32'hFFFF_0000);   // masks to zero
        send_sample(16'h1234, 32'h4000_0000);
        send_sample(16'hEDCB, 32'hC000_0000);
        drain();
        write_reg(REG_OUTPUT_MAX, 32'h0000_7FFF);
        write_reg(REG_CONTROL_MODE, 32'(MODE_OFF_A));
        send_sample(16'h0100, 32'h1234_5678);
        drain();
        write_reg(REG_CONTROL_MODE, 32'hFFFF_FFF0 | 32'(MODE_OFF_B));
        send_sample(16'hFF00, 32'h8765_4321);
        drain();
        // Back to position mode; the previous error carries over.
        write_reg(REG_CONTROL_MODE, 32'(MODE_POSITION));
        send_sample(16'h0010, 32'h0003_0000);
        send_sample(16'h0000, 32'h0000_0000);
        drain();
    endtask

    // Random samples under one idling pattern with a fresh configuration.
    task automatic test_random_phase(int send_pct, int recv_pct, int count);
        random_config();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        send_random(count);
        drain();
    endtask

    // Receiver holds off while requests keep coming, then the sender waits for all results.
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        send_random(20);
        drain();
        send_random(10);
        drain();
    endtask

    // Result receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result with the oldest expected one.
    always @(posedge clk)
    begin
        motor_result_t want;
        motor_result_t got;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[34:16], m_tdata[66:35]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result drive=%0d angle=%0d speed=%0d",
                         $time, got.drive, got.angle, got.speed);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                result_count++;
                if (got.drive !== want.drive)
                begin
                    $display("%0t: drive expected %0d actual %0d", $time, want.drive, got.drive);
                    error_count++;
                end
                if (got.angle !== want.angle)
                begin
                    $display("%0t: angle expected %0d actual %0d", $time, want.angle, got.angle);
                    error_count++;
                end
                if (got.speed !== want.speed)
                begin
                    $display("%0t: speed expected %0d actual %0d", $time, want.speed, got.speed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on the request, result or configuration ports.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no progress", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        result_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        mdl_mode = MODE_POSITION;
        mdl_out_max = 15'h7FFF;
        mdl_count_to_angle = '0;
        mdl_count_to_speed = '0;
        mdl_pos_p = '0;
        mdl_pos_d = '0;
        mdl_vel_p = '0;
        mdl_vel_d = '0;
        foreach (mdl_window[i]) mdl_window[i] = '0;
        mdl_head = 0;
        mdl_window_sum = '0;
        mdl_count_total = '0;
        mdl_last_error = 0;
        mdl_last_drive = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 100);
        test_random_phase(77, 0, 100);
        test_random_phase(0, 77, 100);
        test_random_phase(18, 18, 100);
        test_backpressure();

        $display("Covered field extremes, all four modes, clamp limits and %0d results",
                 result_count);
        $display("under random idling, stalls and a long receiver hold-off.");
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
